// ===== sv/sktf_pkg.sv =====
package sktf_pkg;

  localparam int CHANNELS   = 8;
  localparam int CH_IDX_W   = $clog2(CHANNELS);
  localparam int CH_IN_W    = 3;
  localparam int MEAS_W     = 10;
  localparam int POS_W      = 10;
  localparam int GAIN_W     = 16;
  localparam int VAR_W      = 18;
  localparam int EST_W      = 19;
  localparam int NL_W       = 2;
  localparam int Q_W        = 16;
  localparam int R_W        = 6;
  localparam int DVS_W      = VAR_W + 4;
  localparam int PX_W       = EST_W + GAIN_W;
  localparam int PP_W       = VAR_W + GAIN_W;
  localparam int CNT_W      = $clog2(GAIN_W);
  localparam int BLO_W      = 14;
  localparam int BL1_W      = GAIN_W + EST_W;
  localparam int BL2_W      = BLO_W + POS_W;
  localparam int SUM_W      = BL1_W + 1;
  localparam int PXI_W      = SUM_W - 24;
  localparam int IDX_W      = 1;
  localparam int WDATA_W    = 16;

  localparam logic [IDX_W-1:0] REG_NOISE_LEVEL   = 1'd0;
  localparam logic [IDX_W-1:0] REG_PROCESS_NOISE = 1'd1;

  localparam logic [VAR_W-1:0]  VAR_MAX     = 18'd262143;
  localparam logic [VAR_W-1:0]  VAR_RESET   = 18'd58982;
  localparam logic [EST_W-1:0]  EST_RESET_X = 19'd128000;
  localparam logic [EST_W-1:0]  EST_RESET_Y = 19'd179200;
  localparam logic [POS_W-1:0]  FOL_RESET_X = 10'd500;
  localparam logic [POS_W-1:0]  FOL_RESET_Y = 10'd700;
  localparam logic [Q_W-1:0]    Q_RESET     = 16'd590;
  localparam logic [GAIN_W-1:0] BLEND_EST   = 16'd45554;
  localparam logic [BLO_W-1:0]  BLEND_OLD   = 14'd13828;
  localparam logic [PXI_W-1:0]  X_LOW       = 12'd200;
  localparam logic [PXI_W-1:0]  X_HIGH      = 12'd800;
  localparam logic [PXI_W-1:0]  Y_HIGH      = 12'd700;

  typedef struct packed {
    logic [VAR_W-1:0] pp;
    logic [DVS_W-1:0] dvs;
    logic [EST_W-1:0] diff_x;
    logic [EST_W-1:0] diff_y;
  } serial_op_t;

  typedef struct packed {
    logic [GAIN_W-1:0] k;
    logic [PX_W-1:0]   prod_x;
    logic [PX_W-1:0]   prod_y;
    logic [PP_W-1:0]   prod_p;
  } serial_res_t;

endpackage

// ===== sv/sktf_in_if.sv =====
interface sktf_in_if import sktf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CH_IN_W-1:0] channel;
  logic [MEAS_W-1:0]  meas_x;
  logic [MEAS_W-1:0]  meas_y;

  modport source (output valid, channel, meas_x, meas_y, input ready);
  modport sink (input valid, channel, meas_x, meas_y, output ready);
endinterface

// ===== sv/sktf_out_if.sv =====
interface sktf_out_if import sktf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [GAIN_W-1:0] gain;

  modport source (output valid, pos_x, pos_y, gain, input ready);
  modport sink (input valid, pos_x, pos_y, gain, output ready);
endinterface

// ===== sv/scalar_kalman_track_and_follow_core.sv =====
// Scalar Kalman tracker for CHANNELS objects. Each word on meas updates one
// channel and yields one word on track with the blended, clamped position
// and the gain. An in-range update runs through the 16-step bit-serial gain
// divider before the next word is accepted; a new word is taken while a
// finished result still waits on track. A channel at or above CHANNELS
// returns zeros and changes nothing. Register writes take effect at once
// and are meant for idle periods.
module scalar_kalman_track_and_follow_core import sktf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  sktf_in_if.sink            meas,
  sktf_out_if.source         track,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_index,
  input  logic [WDATA_W-1:0] wr_data
);

  typedef enum logic [2:0] {S_IDLE, S_PRED, S_DIV, S_BLEND, S_OUT} state_t;

  state_t            state;
  logic [NL_W-1:0]   noise_level;
  logic [Q_W-1:0]    process_noise;

  logic [VAR_W-1:0]  variance   [CHANNELS];
  logic [EST_W-1:0]  estimate_x [CHANNELS];
  logic [EST_W-1:0]  estimate_y [CHANNELS];
  logic [POS_W-1:0]  follow_x   [CHANNELS];
  logic [POS_W-1:0]  follow_y   [CHANNELS];

  logic [CH_IDX_W-1:0] ch;
  logic              bad;
  logic [MEAS_W-1:0] mx;
  logic [MEAS_W-1:0] my;
  logic [VAR_W-1:0]  pp;
  logic              dir_x;
  logic              dir_y;
  logic [EST_W-1:0]  est_x_new;
  logic [EST_W-1:0]  est_y_new;
  logic [VAR_W-1:0]  var_new;
  logic [GAIN_W-1:0] k;
  logic [BL1_W-1:0]  m1x;
  logic [BL1_W-1:0]  m1y;
  logic [BL2_W-1:0]  m2x;
  logic [BL2_W-1:0]  m2y;

  logic              out_valid;
  logic [POS_W-1:0]  out_x;
  logic [POS_W-1:0]  out_y;
  logic [GAIN_W-1:0] out_k;

  serial_op_t        sop;
  serial_res_t       sres;
  logic              sdone;
  logic              in_bad;

  logic [R_W-1:0]    r;
  logic [VAR_W:0]    pp_sum;
  logic [VAR_W-1:0]  pp_next;
  logic [EST_W-1:0]  tgt_x;
  logic [EST_W-1:0]  tgt_y;
  logic [EST_W-1:0]  e_x;
  logic [EST_W-1:0]  e_y;
  logic [PP_W:0]     ceil_sum;
  logic [VAR_W:0]    nv_sum;
  logic [EST_W-1:0]  d_x;
  logic [EST_W-1:0]  d_y;
  logic [SUM_W-1:0]  s_x;
  logic [SUM_W-1:0]  s_y;
  logic [PXI_W-1:0]  px;
  logic [PXI_W-1:0]  py;
  logic [PXI_W-1:0]  px_c;
  logic [PXI_W-1:0]  py_c;
  logic              out_free;

  assign in_bad = (int'(meas.channel) >= CHANNELS);

  always_comb begin
    r       = R_W'({noise_level, 3'b000}) + R_W'({noise_level, 1'b0}) + R_W'(10);
    pp_sum  = {1'b0, variance[ch]} + (VAR_W + 1)'(process_noise);
    pp_next = pp_sum[VAR_W] ? VAR_MAX : pp_sum[VAR_W-1:0];
    tgt_x   = {(MEAS_W + 1)'(mx) + (MEAS_W + 1)'(r), 8'b0};
    tgt_y   = {(MEAS_W + 1)'(my) + (MEAS_W + 1)'(r), 8'b0};
    e_x     = estimate_x[ch];
    e_y     = estimate_y[ch];
    sop.pp     = pp_next;
    sop.dvs    = DVS_W'(pp_next) + {r, 16'b0};
    sop.diff_x = (tgt_x >= e_x) ? tgt_x - e_x : e_x - tgt_x;
    sop.diff_y = (tgt_y >= e_y) ? tgt_y - e_y : e_y - tgt_y;

    ceil_sum = {1'b0, sres.prod_p} + (PP_W + 1)'(16'hFFFF);
    nv_sum   = {1'b0, pp} - (VAR_W + 1)'(ceil_sum[PP_W:16]) + (VAR_W + 1)'(process_noise);
    d_x      = sres.prod_x[PX_W-1:16];
    d_y      = sres.prod_y[PX_W-1:16];

    s_x  = SUM_W'(m1x) + SUM_W'({m2x, 8'b0});
    s_y  = SUM_W'(m1y) + SUM_W'({m2y, 8'b0});
    px   = s_x[SUM_W-1:24];
    py   = s_y[SUM_W-1:24];
    px_c = (px <= X_LOW) ? X_LOW : ((px >= X_HIGH) ? X_HIGH : px);
    py_c = (py >= Y_HIGH) ? Y_HIGH : py;

    out_free = !out_valid || track.ready;
  end

  sktf_serial u_serial (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_PRED),
    .op    (sop),
    .res   (sres),
    .done  (sdone)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      noise_level   <= '0;
      process_noise <= Q_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        variance[i]   <= VAR_RESET;
        estimate_x[i] <= EST_RESET_X;
        estimate_y[i] <= EST_RESET_Y;
        follow_x[i]   <= FOL_RESET_X;
        follow_y[i]   <= FOL_RESET_Y;
      end
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_NOISE_LEVEL:   noise_level   <= wr_data[NL_W-1:0];
          REG_PROCESS_NOISE: process_noise <= wr_data[Q_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && track.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (meas.valid) begin
            ch    <= meas.channel[CH_IDX_W-1:0];
            bad   <= in_bad;
            mx    <= meas.meas_x;
            my    <= meas.meas_y;
            state <= in_bad ? S_OUT : S_PRED;
          end
        end
        S_PRED: begin
          pp    <= pp_next;
          dir_x <= (tgt_x >= e_x);
          dir_y <= (tgt_y >= e_y);
          state <= S_DIV;
        end
        S_DIV: begin
          if (sdone) begin
            k         <= sres.k;
            est_x_new <= dir_x ? estimate_x[ch] + d_x : estimate_x[ch] - d_x;
            est_y_new <= dir_y ? estimate_y[ch] + d_y : estimate_y[ch] - d_y;
            var_new   <= nv_sum[VAR_W] ? VAR_MAX : nv_sum[VAR_W-1:0];
            state     <= S_BLEND;
          end
        end
        S_BLEND: begin
          m1x   <= BL1_W'(BLEND_EST) * BL1_W'(est_x_new);
          m1y   <= BL1_W'(BLEND_EST) * BL1_W'(est_y_new);
          m2x   <= BL2_W'(BLEND_OLD) * BL2_W'(follow_x[ch]);
          m2y   <= BL2_W'(BLEND_OLD) * BL2_W'(follow_y[ch]);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (bad) begin
              out_x <= '0;
              out_y <= '0;
              out_k <= '0;
            end else begin
              out_x          <= px_c[POS_W-1:0];
              out_y          <= py_c[POS_W-1:0];
              out_k          <= k;
              variance[ch]   <= var_new;
              estimate_x[ch] <= est_x_new;
              estimate_y[ch] <= est_y_new;
              follow_x[ch]   <= px_c[POS_W-1:0];
              follow_y[ch]   <= py_c[POS_W-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign meas.ready  = (state == S_IDLE);
  assign track.valid = out_valid;
  assign track.pos_x = out_x;
  assign track.pos_y = out_y;
  assign track.gain  = out_k;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    meas.ready |-> !sdone)
    else $error("serial unit finished while idle");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    sdone |-> state == S_DIV)
    else $error("serial result outside divide phase");

  a_x_window: assert property (@(posedge clk) disable iff (rst)
    track.valid |-> (track.pos_x >= POS_W'(200) && track.pos_x <= POS_W'(800)) ||
                    (track.pos_x == '0 && track.pos_y == '0 && track.gain == '0))
    else $error("pos_x outside window");

  a_y_window: assert property (@(posedge clk) disable iff (rst)
    track.valid |-> track.pos_y <= POS_W'(700))
    else $error("pos_y outside window");

endmodule

// ===== sv/sktf_serial.sv =====
// restoring divider, one quotient bit per cycle; each bit also steps three
// MSB-first shift-add products by the gain
module sktf_serial import sktf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  serial_op_t  op,
  output serial_res_t res,
  output logic        done
);

  logic              running;
  logic [CNT_W-1:0]  cnt;
  logic [DVS_W-1:0]  rem;
  serial_op_t        opr;
  logic [GAIN_W-1:0] k;
  logic [PX_W-1:0]   acc_x;
  logic [PX_W-1:0]   acc_y;
  logic [PP_W-1:0]   acc_p;

  logic [DVS_W:0]    shifted;
  logic              q;
  logic [DVS_W-1:0]  rem_next;
  logic [PX_W-1:0]   acc_x_next;
  logic [PX_W-1:0]   acc_y_next;
  logic [PP_W-1:0]   acc_p_next;

  always_comb begin
    shifted    = {rem, 1'b0};
    q          = (shifted >= {1'b0, opr.dvs});
    rem_next   = q ? DVS_W'(shifted - {1'b0, opr.dvs}) : shifted[DVS_W-1:0];
    acc_x_next = {acc_x[PX_W-2:0], 1'b0} + (q ? PX_W'(opr.diff_x) : '0);
    acc_y_next = {acc_y[PX_W-2:0], 1'b0} + (q ? PX_W'(opr.diff_y) : '0);
    acc_p_next = {acc_p[PP_W-2:0], 1'b0} + (q ? PP_W'(opr.pp) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && !start && (cnt == CNT_W'(GAIN_W - 1));
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        opr     <= op;
        rem     <= DVS_W'(op.pp);
        k       <= '0;
        acc_x   <= '0;
        acc_y   <= '0;
        acc_p   <= '0;
      end else if (running) begin
        rem   <= rem_next;
        k     <= {k[GAIN_W-2:0], q};
        acc_x <= acc_x_next;
        acc_y <= acc_y_next;
        acc_p <= acc_p_next;
        cnt   <= cnt + 1'b1;
        if (cnt == CNT_W'(GAIN_W - 1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  assign res.k      = k;
  assign res.prod_x = acc_x;
  assign res.prod_y = acc_y;
  assign res.prod_p = acc_p;

endmodule

// ===== verif/sktf_track_checker.sv =====
`timescale 1ns / 1ps
module sktf_track_checker import sktf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  sktf_in_if                 meas,
  sktf_out_if                track,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_index,
  input  logic [WDATA_W-1:0] wr_data,
  output int                 mismatches,
  output int                 words_due
);

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [GAIN_W-1:0] gain;
  } track_word_t;

  logic [NL_W-1:0]  noise_lvl;
  logic [Q_W-1:0]   q_noise;
  logic [VAR_W-1:0] var_mem   [CHANNELS];
  logic [EST_W-1:0] est_x_mem [CHANNELS];
  logic [EST_W-1:0] est_y_mem [CHANNELS];
  logic [POS_W-1:0] fol_x_mem [CHANNELS];
  logic [POS_W-1:0] fol_y_mem [CHANNELS];

  track_word_t track_due [$];
  int          fail_cnt = 0;

  // step toward (meas + R) in UQ11.8, product truncated toward zero
  function automatic logic [EST_W-1:0] pull_toward(logic [EST_W-1:0] e,
                                                   logic [MEAS_W-1:0] m,
                                                   logic [63:0] r,
                                                   logic [63:0] k);
    logic [63:0] target;
    logic [63:0] delta;
    target = (64'(m) + r) << 8;
    if (target >= 64'(e)) begin
      delta = ((target - 64'(e)) * k) >> 16;
      return EST_W'(64'(e) + delta);
    end
    delta = ((64'(e) - target) * k) >> 16;
    return EST_W'(64'(e) - delta);
  endfunction

  function automatic logic [63:0] blend_pos(logic [EST_W-1:0] e, logic [POS_W-1:0] old);
    logic [63:0] acc;
    acc = 64'(BLEND_EST) * 64'(e) + ((64'(BLEND_OLD) * 64'(old)) << 8);
    return (acc >> 24) & 64'hFFFF_FFFF;
  endfunction

  function automatic track_word_t kalman_tick(logic [CH_IN_W-1:0] ch,
                                              logic [MEAS_W-1:0] mx,
                                              logic [MEAS_W-1:0] my);
    track_word_t w;
    logic [63:0] r;
    logic [63:0] pp;
    logic [63:0] k;
    logic [63:0] nv;
    logic [63:0] px;
    logic [63:0] py;
    w = '0;
    if (int'(ch) >= CHANNELS) return w;
    r  = (64'(noise_lvl) + 64'd1) * 64'd10;
    pp = 64'(var_mem[ch]) + 64'(q_noise);
    if (pp > 64'(VAR_MAX)) pp = 64'(VAR_MAX);
    k = ((pp << 16) / (pp + (r << 16))) & 64'hFFFF;
    est_x_mem[ch] = pull_toward(est_x_mem[ch], mx, r, k);
    est_y_mem[ch] = pull_toward(est_y_mem[ch], my, r, k);
    nv = (((64'd65536 - k) * pp) >> 16) + 64'(q_noise);
    if (nv > 64'(VAR_MAX)) nv = 64'(VAR_MAX);
    var_mem[ch] = VAR_W'(nv);
    px = blend_pos(est_x_mem[ch], fol_x_mem[ch]);
    py = blend_pos(est_y_mem[ch], fol_y_mem[ch]);
    if (px <= 64'(X_LOW)) px = 64'(X_LOW);
    if (px >= 64'(X_HIGH)) px = 64'(X_HIGH);
    if (py >= 64'(Y_HIGH)) py = 64'(Y_HIGH);
    fol_x_mem[ch] = POS_W'(px);
    fol_y_mem[ch] = POS_W'(py);
    w.pos_x = POS_W'(px);
    w.pos_y = POS_W'(py);
    w.gain  = GAIN_W'(k);
    return w;
  endfunction

  always @(posedge clk) begin
    track_word_t seen;
    track_word_t due;
    if (rst) begin
      noise_lvl = '0;
      q_noise   = Q_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        var_mem[i]   = VAR_RESET;
        est_x_mem[i] = EST_RESET_X;
        est_y_mem[i] = EST_RESET_Y;
        fol_x_mem[i] = FOL_RESET_X;
        fol_y_mem[i] = FOL_RESET_Y;
      end
      track_due.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_NOISE_LEVEL:   noise_lvl = wr_data[NL_W-1:0];
          REG_PROCESS_NOISE: q_noise   = wr_data[Q_W-1:0];
          default: ;
        endcase
      end
      if (meas.valid && meas.ready)
        track_due.push_back(kalman_tick(meas.channel, meas.meas_x, meas.meas_y));
      if (track.valid && track.ready) begin
        seen.pos_x = track.pos_x;
        seen.pos_y = track.pos_y;
        seen.gain  = track.gain;
        if (track_due.size() == 0) begin
          $error("track word with nothing due: pos_x %0d pos_y %0d gain %0d",
                 seen.pos_x, seen.pos_y, seen.gain);
          fail_cnt++;
        end else begin
          due = track_due.pop_front();
          if (seen.pos_x !== due.pos_x) begin
            $error("pos_x mismatch: expected %0d, got %0d", due.pos_x, seen.pos_x);
            fail_cnt++;
          end
          if (seen.pos_y !== due.pos_y) begin
            $error("pos_y mismatch: expected %0d, got %0d", due.pos_y, seen.pos_y);
            fail_cnt++;
          end
          if (seen.gain !== due.gain) begin
            $error("gain mismatch: expected %0d, got %0d", due.gain, seen.gain);
            fail_cnt++;
          end
        end
      end
    end
    words_due  <= track_due.size();
    mismatches <= fail_cnt;
  end

endmodule

// ===== verif/tb_scalar_kalman_track_and_follow_core.sv =====
`timescale 1ns / 1ps
module tb_scalar_kalman_track_and_follow_core;
  import sktf_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int UPDATE_CYCLES = 21;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 400;

  logic               clk = 1'b0;
  logic               rst;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_index;
  logic [WDATA_W-1:0] wr_data;
  int                 mismatches;
  int                 words_due;

  sktf_in_if  meas ();
  sktf_out_if track ();

  scalar_kalman_track_and_follow_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .meas     (meas),
    .track    (track),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  sktf_track_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .meas       (meas),
    .track      (track),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // output side: random stalls, one long hold-off, then a stretch with none
  int taken     = 0;
  int hold_left = 0;
  bit held      = 1'b0;

  always @(posedge clk) begin
    if (track.valid && track.ready) taken++;
    if (rst) begin
      track.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      track.ready <= 1'b0;
    end else if (!held && taken >= HOLD_AT) begin
      held      = 1'b1;
      hold_left = HOLD_CYCLES;
      track.ready <= 1'b0;
    end else begin
      track.ready <= (taken >= 600 && taken < 800) || ($urandom_range(0, 99) >= 17);
    end
  end

  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (meas.valid && meas.ready) || (track.valid && track.ready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  bit calm_send = 1'b0;
  int aim_x [CHANNELS];
  int aim_y [CHANNELS];

  task automatic send_word(logic [CH_IN_W-1:0] ch, logic [MEAS_W-1:0] mx,
                           logic [MEAS_W-1:0] my);
    while (!calm_send && $urandom_range(0, 99) < 17) begin
      meas.valid <= 1'b0;
      @(posedge clk);
    end
    meas.valid   <= 1'b1;
    meas.channel <= ch;
    meas.meas_x  <= mx;
    meas.meas_y  <= my;
    do @(posedge clk); while (!meas.ready);
  endtask

  // mostly slow drift per channel, some jumps to the rails, some noise
  task automatic send_random(int n);
    int ch;
    int mode;
    int mx;
    int my;
    for (int i = 0; i < n; i++) begin
      ch   = $urandom_range(0, CHANNELS - 1);
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        aim_x[ch] = $urandom_range(0, 1023);
        aim_y[ch] = $urandom_range(0, 1023);
      end
      if (mode < 6) begin
        aim_x[ch] = aim_x[ch] + $urandom_range(0, 40) - 20;
        aim_y[ch] = aim_y[ch] + $urandom_range(0, 40) - 20;
        if (aim_x[ch] < 0) aim_x[ch] = 0;
        if (aim_x[ch] > 1023) aim_x[ch] = 1023;
        if (aim_y[ch] < 0) aim_y[ch] = 0;
        if (aim_y[ch] > 1023) aim_y[ch] = 1023;
        mx = aim_x[ch];
        my = aim_y[ch];
      end else if (mode < 8) begin
        mx = $urandom_range(0, 1) ? 1023 : 0;
        my = $urandom_range(0, 1) ? 1023 : 0;
      end else begin
        mx = $urandom_range(0, 1023);
        my = $urandom_range(0, 1023);
      end
      send_word(CH_IN_W'(ch), MEAS_W'(mx), MEAS_W'(my));
    end
  endtask

  task automatic settle();
    meas.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  // upper data bits of the noise level word are junk on purpose
  task automatic set_noise(logic [NL_W-1:0] lvl, logic [Q_W-1:0] q);
    logic [WDATA_W-1:0] lvl_word;
    lvl_word           = WDATA_W'($urandom);
    lvl_word[NL_W-1:0] = lvl;
    wr_en    <= 1'b1;
    wr_index <= REG_NOISE_LEVEL;
    wr_data  <= lvl_word;
    @(posedge clk);
    wr_index <= REG_PROCESS_NOISE;
    wr_data  <= WDATA_W'(q);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    wr_en        = 1'b0;
    wr_index     = '0;
    wr_data      = '0;
    meas.valid   = 1'b0;
    meas.channel = '0;
    meas.meas_x  = '0;
    meas.meas_y  = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      aim_x[i] = 500;
      aim_y[i] = 700;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: rails, clamps, alternating bits
    send_word(3'd0, 10'd0, 10'd0);
    send_word(3'd0, 10'd0, 10'd0);
    send_word(3'd0, 10'd1023, 10'd1023);
    send_word(3'd0, 10'd1023, 10'd1023);
    send_word(3'd1, 10'd1023, 10'd0);
    send_word(3'd1, 10'd0, 10'd1023);
    send_word(3'd2, 10'h155, 10'h2AA);
    send_word(3'd3, 10'h2AA, 10'h155);
    send_word(3'd4, 10'd500, 10'd700);
    send_word(3'd5, 10'd200, 10'd0);
    send_word(3'd6, 10'd800, 10'd700);
    send_word(3'd7, 10'd1023, 10'd0);
    send_random(130);
    settle();

    for (int ph = 1; ph <= 7; ph++) begin
      case (ph)
        1:       set_noise(2'd3, 16'hFFFF);
        2:       set_noise(2'd0, 16'h0000);
        3:       set_noise(2'd1, Q_RESET);
        4:       set_noise(2'd2, Q_W'($urandom_range(1, 4000)));
        5:       set_noise(2'd0, 16'hFFFF);
        6:       set_noise(2'd3, 16'h0000);
        default: set_noise(NL_W'($urandom_range(0, 3)), Q_W'($urandom));
      endcase
      // largest R with largest Q drives the variance into saturation
      if (ph == 1) repeat (6) send_word(3'd3, 10'd0, 10'd1023);
      calm_send = (ph == 3);
      send_random(130);
      settle();
    end

    repeat (UPDATE_CYCLES + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sktf_pkg.sv
sv/sktf_in_if.sv
sv/sktf_out_if.sv
sv/sktf_serial.sv
sv/scalar_kalman_track_and_follow_core.sv
verif/sktf_track_checker.sv
verif/tb_scalar_kalman_track_and_follow_core.sv
